// ----- sv/gimli_pkg.sv -----
`timescale 1ns / 1ps

package gimli_pkg;

    localparam int WORD_W      = 32;
    localparam int NUM_WORDS   = 12;
    localparam int MAX_ROUNDS  = 24;
    localparam int RND_W       = 5;

    typedef logic [WORD_W-1:0] word_t;
    typedef word_t [NUM_WORDS-1:0] state_t;

    localparam word_t ROUND_CONST = 32'h9e377900;

endpackage

// ----- sv/gimli_in_if.sv -----
`timescale 1ns / 1ps

interface gimli_in_if;

    logic        valid;
    logic        ready;
    logic [31:0] in_word_0;
    logic [31:0] in_word_1;
    logic [31:0] in_word_2;
    logic [31:0] in_word_3;
    logic [31:0] in_word_4;
    logic [31:0] in_word_5;
    logic [31:0] in_word_6;
    logic [31:0] in_word_7;
    logic [31:0] in_word_8;
    logic [31:0] in_word_9;
    logic [31:0] in_word_10;
    logic [31:0] in_word_11;

    modport source (
        output valid,
        input  ready,
        output in_word_0, in_word_1, in_word_2, in_word_3,
        output in_word_4, in_word_5, in_word_6, in_word_7,
        output in_word_8, in_word_9, in_word_10, in_word_11
    );

    modport sink (
        input  valid,
        output ready,
        input  in_word_0, in_word_1, in_word_2, in_word_3,
        input  in_word_4, in_word_5, in_word_6, in_word_7,
        input  in_word_8, in_word_9, in_word_10, in_word_11
    );

endinterface

// ----- sv/gimli_out_if.sv -----
`timescale 1ns / 1ps

interface gimli_out_if;

    logic        valid;
    logic        ready;
    logic [31:0] out_word_0;
    logic [31:0] out_word_1;
    logic [31:0] out_word_2;
    logic [31:0] out_word_3;
    logic [31:0] out_word_4;
    logic [31:0] out_word_5;
    logic [31:0] out_word_6;
    logic [31:0] out_word_7;
    logic [31:0] out_word_8;
    logic [31:0] out_word_9;
    logic [31:0] out_word_10;
    logic [31:0] out_word_11;

    modport source (
        output valid,
        input  ready,
        output out_word_0, out_word_1, out_word_2, out_word_3,
        output out_word_4, out_word_5, out_word_6, out_word_7,
        output out_word_8, out_word_9, out_word_10, out_word_11
    );

    modport sink (
        input  valid,
        output ready,
        input  out_word_0, out_word_1, out_word_2, out_word_3,
        input  out_word_4, out_word_5, out_word_6, out_word_7,
        input  out_word_8, out_word_9, out_word_10, out_word_11
    );

endinterface

// ----- sv/gimli_cell.sv -----
`timescale 1ns / 1ps

module gimli_cell #(
    parameter int ROUND_NUM = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  gimli_pkg::state_t in_state,
    output logic             out_valid,
    input  logic             out_ready,
    output gimli_pkg::state_t out_state
);
    import gimli_pkg::*;

    localparam logic [RND_W-1:0] RND = ROUND_NUM[RND_W-1:0];
    localparam word_t RND_XOR = ROUND_CONST | word_t'(RND);

    logic   valid_reg;
    state_t state_reg;
    state_t state_next;

    // SP-box on each column, then the swap / constant step of this round
    always_comb
    begin
        word_t  x;
        word_t  y;
        word_t  z;
        state_t sp;
        sp = in_state;
        for (int c = 0; c < 4; c++)
        begin
            x = {in_state[c][7:0], in_state[c][31:8]};
            y = {in_state[4+c][22:0], in_state[4+c][31:23]};
            z = in_state[8+c];
            sp[8+c] = x ^ (z << 1) ^ ((y & z) << 2);
            sp[4+c] = y ^ x ^ ((x | z) << 1);
            sp[c]   = z ^ y ^ ((x & y) << 3);
        end
        state_next = sp;
        if (RND[1:0] == 2'd0)
        begin
            state_next[0] = sp[1] ^ RND_XOR;
            state_next[1] = sp[0];
            state_next[2] = sp[3];
            state_next[3] = sp[2];
        end
        else if (RND[1:0] == 2'd2)
        begin
            state_next[0] = sp[2];
            state_next[1] = sp[3];
            state_next[2] = sp[0];
            state_next[3] = sp[1];
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_state = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/gimli_permutation_384_top.sv -----
`timescale 1ns / 1ps

// Gimli 384-bit permutation, one round per pipeline cell.
// Channels: in_chan (sink) takes a request of twelve 32-bit state words,
// out_chan (source) returns the permuted twelve words. A transfer happens
// on a rising clk edge with valid and ready both high.
// Each cell registers one round, so a request is registered once per cell
// on its way from accept to out_chan.valid. Rounds count down NUM_ROUNDS .. 1.
// Throughput: one request per cycle while out_chan.ready is held high.
// Stall: when out_chan.ready is low the last cell holds its result; ready
// ripples back so empty cells further up keep filling, and in_chan.ready
// drops only when every cell holds a request.
// Reset: rst_n (async, active low) empties all cells; any request in
// flight is dropped. No state is carried between requests.
module gimli_permutation_384_top #(
    parameter int NUM_ROUNDS = gimli_pkg::MAX_ROUNDS
) (
    input  logic        clk,
    input  logic        rst_n,
    gimli_in_if.sink    in_chan,
    gimli_out_if.source out_chan
);
    import gimli_pkg::*;

    logic   valid_vec [NUM_ROUNDS+1];
    logic   rdy_vec   [NUM_ROUNDS+1];
    state_t st_vec    [NUM_ROUNDS+1];

    assign valid_vec[0] = in_chan.valid;
    assign in_chan.ready = rdy_vec[0];
    assign st_vec[0] = {in_chan.in_word_11, in_chan.in_word_10, in_chan.in_word_9,
                        in_chan.in_word_8, in_chan.in_word_7, in_chan.in_word_6,
                        in_chan.in_word_5, in_chan.in_word_4, in_chan.in_word_3,
                        in_chan.in_word_2, in_chan.in_word_1, in_chan.in_word_0};

    genvar i;
    generate
        for (i = 0; i < NUM_ROUNDS; i++)
        begin : g_cell
            gimli_cell #(
                .ROUND_NUM(NUM_ROUNDS - i)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .in_valid (valid_vec[i]),
                .in_ready (rdy_vec[i]),
                .in_state (st_vec[i]),
                .out_valid(valid_vec[i+1]),
                .out_ready(rdy_vec[i+1]),
                .out_state(st_vec[i+1])
            );
        end
    endgenerate

    assign rdy_vec[NUM_ROUNDS] = out_chan.ready;
    assign out_chan.valid      = valid_vec[NUM_ROUNDS];
    assign out_chan.out_word_0  = st_vec[NUM_ROUNDS][0];
    assign out_chan.out_word_1  = st_vec[NUM_ROUNDS][1];
    assign out_chan.out_word_2  = st_vec[NUM_ROUNDS][2];
    assign out_chan.out_word_3  = st_vec[NUM_ROUNDS][3];
    assign out_chan.out_word_4  = st_vec[NUM_ROUNDS][4];
    assign out_chan.out_word_5  = st_vec[NUM_ROUNDS][5];
    assign out_chan.out_word_6  = st_vec[NUM_ROUNDS][6];
    assign out_chan.out_word_7  = st_vec[NUM_ROUNDS][7];
    assign out_chan.out_word_8  = st_vec[NUM_ROUNDS][8];
    assign out_chan.out_word_9  = st_vec[NUM_ROUNDS][9];
    assign out_chan.out_word_10 = st_vec[NUM_ROUNDS][10];
    assign out_chan.out_word_11 = st_vec[NUM_ROUNDS][11];

    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        (in_chan.valid && in_chan.ready) |=> valid_vec[1])
        else $error("accepted request did not reach first cell");

    a_first_cell_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec[1] && !rdy_vec[2 > NUM_ROUNDS ? NUM_ROUNDS : 1]) |=>
        (valid_vec[1] && $stable(st_vec[1])))
        else $error("stalled first cell lost its request");

    a_flow_through: assert property (@(posedge clk) disable iff (!rst_n)
        out_chan.ready |-> in_chan.ready)
        else $error("input stalled while output drains");

endmodule
